// File: design/olide_pkg.sv
// ----------------------------------------------------------------------------
// olide_pkg
// Request/result types and operation and status codes for the ordered list
// engine.
// ----------------------------------------------------------------------------
package olide_pkg;

  localparam logic [1:0] FN_GET    = 2'd0;
  localparam logic [1:0] FN_LOCATE = 2'd1;
  localparam logic [1:0] FN_INSERT = 2'd2;
  localparam logic [1:0] FN_DELETE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] position;
    logic [7:0] value_in;
  } olide_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] value_out;
    logic [6:0] found_position;
    logic [6:0] list_count;
    logic       is_empty;
  } olide_rsp_t;

endpackage

// File: design/ordered_list_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_engine
// Array list of up to DEPTH bytes: get, insert, delete by 1-based position,
// locate by value; walked one entry per cycle via a single-port-pair memory.
// ----------------------------------------------------------------------------
//  channel | ports                        | moves
//  --------+------------------------------+-----------------------------------
//  in      | in_valid  in_ready  in_data  | request: func, position, value_in
//  out     | out_valid out_ready out_data | result: status, value, counts
//
//  One request at a time; in_ready is high only when the engine is idle.
//  Locate stops at the first match; insert and delete walk only the entries
//  from the position to the end; bad or full requests skip the walk.
//  The walk moves one memory entry per cycle (one read, one write port).
//  A stalled result holds in out_data until out_ready. rst_n clears the
//  length and the sequencer; the store itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_engine #(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  olide_pkg::olide_req_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output olide_pkg::olide_rsp_t  out_data
);
  import olide_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > 7) ? LW : 7) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pa_r, pa_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic          pend_r, pend_nxt;
  logic          first_r, first_nxt;
  logic          down_r, down_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    vout_r, vout_nxt;
  logic [6:0]    found_r, found_nxt;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic [CW-1:0] pos_c, len_c;
  logic          pos_bad, ins_bad, full;

  assign pos_c   = CW'(in_data.position);
  assign len_c   = CW'(len_r);
  assign pos_bad = (pos_c == '0) || (pos_c > len_c);
  assign ins_bad = (pos_c == '0) || (pos_c > (len_c + CW'(1)));
  assign full    = (len_c == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pa_nxt     = pa_r;
    base_nxt   = base_r;
    pend_nxt   = 1'b0;
    first_nxt  = first_r;
    down_nxt   = down_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    vout_nxt   = vout_r;
    found_nxt  = found_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.func;
          val_nxt    = in_data.value_in;
          base_nxt   = AW'(pos_c - CW'(1));
          status_nxt = ST_OK;
          vout_nxt   = '0;
          found_nxt  = '0;
          first_nxt  = 1'b1;
          down_nxt   = 1'b0;
          idx_nxt    = AW'(pos_c - CW'(1));
          cnt_nxt    = LW'(len_c - pos_c + CW'(1));
          state_nxt  = S_WALK;
          case (in_data.func)
            FN_GET: begin
              cnt_nxt = LW'(1);
              if (pos_bad) begin
                status_nxt = ST_BAD;
                state_nxt  = S_OUT;
              end
            end
            FN_LOCATE: begin
              status_nxt = ST_BAD;
              idx_nxt    = '0;
              cnt_nxt    = len_r;
            end
            FN_INSERT: begin
              down_nxt = 1'b1;
              idx_nxt  = AW'(len_c - CW'(1));
              if (ins_bad) begin
                status_nxt = ST_BAD;
                state_nxt  = S_OUT;
              end else if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end
            end
            default: begin
              if (pos_bad) begin
                status_nxt = ST_BAD;
                state_nxt  = S_OUT;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        if (cnt_r != '0) begin
          pend_nxt = 1'b1;
          pa_nxt   = idx_r;
          cnt_nxt  = cnt_r - LW'(1);
          idx_nxt  = down_r ? (idx_r - AW'(1)) : (idx_r + AW'(1));
        end else begin
          if (op_r == FN_INSERT) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_OUT;
          end
          if (op_r == FN_DELETE) begin
            len_nxt = len_r - LW'(1);
          end
        end
        if (pend_r) begin
          case (op_r)
            FN_GET: begin
              vout_nxt = rd_data_r;
            end
            FN_LOCATE: begin
              if (rd_data_r == val_r) begin
                found_nxt  = 7'({1'b0, pa_r} + (AW + 1)'(1));
                status_nxt = ST_OK;
                cnt_nxt    = '0;
                pend_nxt   = 1'b0;
                state_nxt  = S_OUT;
              end
            end
            FN_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pa_r + AW'(1);
            end
            default: begin
              if (first_r) begin
                vout_nxt  = rd_data_r;
                first_nxt = 1'b0;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pa_r - AW'(1);
              end
            end
          endcase
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = base_r;
        mem_wdata = val_r;
        len_nxt   = len_r + LW'(1);
        state_nxt = S_OUT;
      end

      default: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pa_r     <= pa_nxt;
    base_r   <= base_nxt;
    first_r  <= first_nxt;
    down_r   <= down_nxt;
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
    found_r  <= found_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  assign out_data.status         = status_r;
  assign out_data.value_out      = vout_r;
  assign out_data.found_position = found_r;
  assign out_data.list_count     = 7'(len_r);
  assign out_data.is_empty       = (len_r == '0);

endmodule

// File: dv/tb_ordered_list_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete_engine
// Self-checking bench for the ordered list engine. A shadow copy of the list
// predicts every result, and each returned result is compared field by field
// in request order. The stimulus covers directed corner cases, fill to full
// and drain, long output back-pressure, random well-formed traffic and raw
// random requests, with random idle on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_list_insert_delete_engine;
  import olide_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int WDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  olide_req_t in_data;
  logic       out_valid;
  logic       out_ready;
  olide_rsp_t out_data;

  logic [7:0] golden_list [LIST_DEPTH];
  int         golden_len;
  olide_rsp_t expected_rsp_q[$];

  int err_cnt;
  int idle_cycles;
  int peak_len;
  int op_cnt [4];
  int status_cnt [3];

  bit tx_idle_on;
  int tx_burst_left;
  int rx_mode;
  int rx_hold_left;
  int rx_tick;

  ordered_list_insert_delete_engine #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow list update; returns the result the engine owes for this request.
  function automatic olide_rsp_t list_apply(olide_req_t r);
    olide_rsp_t rsp;
    int p;
    rsp = '0;
    rsp.status = ST_OK;
    p = int'(r.position);
    case (r.func)
      FN_GET: begin
        if (p < 1 || p > golden_len) rsp.status = ST_BAD;
        else rsp.value_out = golden_list[p-1];
      end
      FN_LOCATE: begin
        rsp.status = ST_BAD;
        for (int i = 0; i < golden_len; i++) begin
          if (golden_list[i] == r.value_in) begin
            rsp.found_position = 7'(i + 1);
            rsp.status = ST_OK;
            break;
          end
        end
      end
      FN_INSERT: begin
        if (p < 1 || p > golden_len + 1) begin
          rsp.status = ST_BAD;
        end else if (golden_len >= LIST_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          for (int i = golden_len; i > p - 1; i--) golden_list[i] = golden_list[i-1];
          golden_list[p-1] = r.value_in;
          golden_len++;
        end
      end
      default: begin
        if (p < 1 || p > golden_len) begin
          rsp.status = ST_BAD;
        end else begin
          rsp.value_out = golden_list[p-1];
          for (int i = p - 1; i + 1 < golden_len; i++) golden_list[i] = golden_list[i+1];
          golden_len--;
        end
      end
    endcase
    rsp.list_count = 7'(golden_len);
    rsp.is_empty = (golden_len == 0);
    return rsp;
  endfunction

  // Caller is at a rising edge. Request is predicted on acceptance.
  task automatic send_req(input logic [1:0] fn, input int pos, input int val);
    olide_req_t r;
    r.func = fn;
    r.position = 7'(pos);
    r.value_in = 8'(val);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_rsp_q.push_back(list_apply(r));
    op_cnt[fn]++;
    if (golden_len > peak_len) peak_len = golden_len;
    if (tx_idle_on) begin
      tx_burst_left--;
      if (tx_burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        tx_burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed requests; length is steered to stay away from the ends
  // except now and then.
  task automatic send_random_req();
    int pick;
    int fn;
    int pos;
    int val;
    pick = $urandom_range(0, 99);
    if (golden_len < 6) fn = (pick < 60) ? FN_INSERT : (pick < 75) ? FN_LOCATE :
                             (pick < 88) ? FN_GET : FN_DELETE;
    else if (golden_len > 58) fn = (pick < 45) ? FN_DELETE : (pick < 65) ? FN_GET :
                                   (pick < 80) ? FN_LOCATE : FN_INSERT;
    else fn = (pick < 30) ? FN_INSERT : (pick < 55) ? FN_DELETE :
              (pick < 78) ? FN_GET : FN_LOCATE;
    val = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 127);
    else if (fn == FN_INSERT) pos = $urandom_range(1, golden_len + 1);
    else if (golden_len > 0) pos = $urandom_range(1, golden_len);
    else pos = $urandom_range(0, 127);
    if (fn == FN_LOCATE && golden_len > 0 && $urandom_range(0, 2) != 0)
      val = golden_list[$urandom_range(0, golden_len - 1)];
    send_req(2'(fn), pos, val);
  endtask

  task automatic test_directed();
    send_req(FN_GET, 0, 8'h00);
    send_req(FN_GET, 1, 8'h00);
    send_req(FN_DELETE, 1, 8'h00);
    send_req(FN_LOCATE, 0, 8'h00);
    send_req(FN_INSERT, 0, 8'h11);
    send_req(FN_INSERT, 2, 8'h22);
    send_req(FN_INSERT, 1, 8'h00);
    send_req(FN_INSERT, 2, 8'hFF);
    send_req(FN_INSERT, 1, 8'h80);
    send_req(FN_INSERT, 2, 8'hFF);
    send_req(FN_GET, 1, 8'h00);
    send_req(FN_GET, 4, 8'h00);
    send_req(FN_GET, 5, 8'h00);
    send_req(FN_GET, 127, 8'hFF);
    send_req(FN_LOCATE, 127, 8'hFF);
    send_req(FN_LOCATE, 0, 8'h55);
    send_req(FN_LOCATE, 0, 8'h80);
    send_req(FN_DELETE, 2, 8'h00);
    send_req(FN_DELETE, 3, 8'h00);
    send_req(FN_DELETE, 0, 8'h00);
    send_req(FN_INSERT, 127, 8'h7F);
    send_req(FN_DELETE, 1, 8'h00);
    send_req(FN_DELETE, 1, 8'h00);
    send_req(FN_DELETE, 1, 8'h00);
    wait_drain();
  endtask

  task automatic test_fill_and_drain();
    send_req(FN_INSERT, 1, 8'h00);
    send_req(FN_INSERT, golden_len + 1, 8'hFF);
    while (golden_len < LIST_DEPTH)
      send_req(FN_INSERT, $urandom_range(1, golden_len + 1), $urandom_range(0, 31));
    send_req(FN_INSERT, LIST_DEPTH + 1, 8'hA5);
    send_req(FN_INSERT, LIST_DEPTH + 2, 8'hA5);
    send_req(FN_INSERT, 1, 8'h5A);
    send_req(FN_INSERT, 0, 8'h5A);
    send_req(FN_GET, LIST_DEPTH, 8'h00);
    send_req(FN_GET, LIST_DEPTH + 1, 8'h00);
    send_req(FN_LOCATE, 0, 8'hFF);
    send_req(FN_LOCATE, 0, golden_list[LIST_DEPTH-1]);
    send_req(FN_LOCATE, 0, 8'hC3);
    send_req(FN_DELETE, LIST_DEPTH, 8'h00);
    while (golden_len > 0) send_req(FN_DELETE, $urandom_range(1, golden_len), 8'h00);
    send_req(FN_DELETE, 1, 8'h00);
    wait_drain();
  endtask

  task automatic test_backpressure();
    for (int k = 0; k < 16; k++) send_req(FN_INSERT, $urandom_range(1, golden_len + 1),
                                          $urandom_range(0, 255));
    wait_drain();
    rx_hold_left = HOLD_CYCLES;
    for (int k = 0; k < 12; k++) send_random_req();
    wait_drain();
    rx_hold_left = HOLD_CYCLES;
    for (int k = 0; k < 12; k++) send_random_req();
    wait_drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      rx_mode = phase % 4;
      tx_idle_on = (phase != 1);
      for (int k = 0; k < 150; k++) send_random_req();
    end
    wait_drain();
  endtask

  task automatic test_raw_requests();
    rx_mode = 1;
    tx_idle_on = 1'b1;
    for (int k = 0; k < 110; k++)
      send_req(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 255));
    wait_drain();
  endtask

  // Receiver: long hold-off first, otherwise the current stall pattern.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ((rx_tick % 7) < 3);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    olide_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        err_cnt++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("value_out", want.value_out, out_data.value_out);
        check_field("found_position", want.found_position, out_data.found_position);
        check_field("list_count", want.list_count, out_data.list_count);
        check_field("is_empty", want.is_empty, out_data.is_empty);
        if (want.status <= ST_FULL) status_cnt[want.status]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
          $display("timeout: no request or result moved for %0d cycles", WDOG_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    golden_len = 0;
    err_cnt = 0;
    idle_cycles = 0;
    peak_len = 0;
    tx_idle_on = 1'b1;
    tx_burst_left = 4;
    rx_mode = 0;
    rx_hold_left = 0;
    rx_tick = 0;
    foreach (op_cnt[i]) op_cnt[i] = 0;
    foreach (status_cnt[i]) status_cnt[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    rx_mode = 1;
    test_backpressure();
    test_random_traffic();
    test_raw_requests();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      $error("%0d results never arrived", expected_rsp_q.size());
      err_cnt++;
    end
    $display("requests: get %0d, locate %0d, insert %0d, delete %0d; peak length %0d",
             op_cnt[FN_GET], op_cnt[FN_LOCATE], op_cnt[FN_INSERT], op_cnt[FN_DELETE],
             peak_len);
    $display("results: ok %0d, bad position/miss %0d, full %0d; errors %0d",
             status_cnt[ST_OK], status_cnt[ST_BAD], status_cnt[ST_FULL], err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
